[rtl/dual_quadrature_position_speed_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the dual quadrature position and speed unit
// Assertions are compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_POSITION_SPEED_UNIT_DEFINES_SVH
`define DUAL_QUADRATURE_POSITION_SPEED_UNIT_DEFINES_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define DQPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dqps assertion failed");
// expression that must never be true outside reset
`define DQPS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("dqps forbidden condition seen");
`else
`define DQPS_ASSERT(lbl, prop)
`define DQPS_ASSERT_NEVER(lbl, expr)
`endif

`endif

[rtl/dqps_pkg.sv]
// ---------------------------------------------------------------------------
// dqps_pkg
// Shared codes, types and the quadrature step function
// ---------------------------------------------------------------------------
package dqps_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned CountW = 32;

  // mode codes of an input transfer (code 3 behaves as a plain sample)
  localparam logic [ModeW-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [ModeW-1:0] MODE_TICK   = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 2'd2;

  // two-bit signed step codes
  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_UP   = 2'b01;
  localparam logic [1:0] STEP_DOWN = 2'b11;

  // control of the item held in the second stage
  typedef struct packed {
    logic valid;
    logic tick;
    logic clear;
  } stage_ctrl_t;

  // x4 decode of one encoder from old and new pin levels
  function automatic logic [1:0] quad_step(input logic old_a, input logic old_b,
                                           input logic a, input logic b);
    logic same;
    logic ch_a;
    logic ch_b;
    logic [1:0] step;
    same = (a == b);
    ch_a = old_a ^ a;
    ch_b = old_b ^ b;
    step = STEP_NONE;
    if (ch_a && !ch_b) begin
      step = same ? STEP_UP : STEP_DOWN;
    end else if (ch_b && !ch_a) begin
      step = same ? STEP_DOWN : STEP_UP;
    end
    return step;
  endfunction

endpackage

[rtl/dual_quadrature_position_speed_unit.sv]
// ---------------------------------------------------------------------------
// dual_quadrature_position_speed_unit
// Two x4 quadrature decoders with windowed speed over a ring of deltas
// ---------------------------------------------------------------------------
// Usage:
//   The slave stream carries one pin sample per transfer: mode selects a
//   plain sample, a sample followed by a speed tick, or a clear of all
//   counts. Every accepted transfer yields exactly one master transfer with
//   both positions and both speeds as they stand after that sample.
//   Path: stage one decodes and reads the delta ring, stage two updates the
//   ring and the sums, then the output register holds the offered result.
//   Throughput: one transfer per cycle while results are taken; the ring
//   memory has one read and one write port, and consecutive ticks address
//   different entries when WINDOW_DEPTH is above one.
//   Reset: positions, sums and the ring index go to zero, the last pin
//   levels to all ones; ring entries read as zero through per-entry valid
//   flags, so no clearing pass is needed and the unit is ready at once.
//   Stall: while the master side is held off, results wait in the output
//   register and in stage two; s_axis_tready_o drops only when both are full.
// ---------------------------------------------------------------------------
`include "dual_quadrature_position_speed_unit_defines.svh"

module dual_quadrature_position_speed_unit #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // mode[1:0], left_a, left_b, right_a, right_b, zeros
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o   // left_position, right_position, left_speed, right_speed
);

  localparam int unsigned SlotW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW    = dqps_pkg::CountW;

  dqps_pkg::stage_ctrl_t s2_ctrl;
  logic [SlotW-1:0]      s2_slot, rd_slot;
  logic [CW-1:0]         s2_ldelta, s2_rdelta, s2_lpos, s2_rpos;
  logic [CW-1:0]         left_speed, right_speed;
  logic                  in_fire, s2_fire, rd_en;
  logic                  out_valid_q;
  logic [4*CW-1:0]       out_data_q;

  // handshake: stage two moves on when the output register is free or taken
  assign s2_fire         = s2_ctrl.valid && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s2_ctrl.valid || s2_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  dqps_decode #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_fire_i        (in_fire),
    .mode_i           (s_axis_tdata_i[1:0]),
    .pins_i           (s_axis_tdata_i[5:2]),
    .s2_fire_i        (s2_fire),
    .s2_ctrl_o        (s2_ctrl),
    .s2_slot_o        (s2_slot),
    .s2_left_delta_o  (s2_ldelta),
    .s2_right_delta_o (s2_rdelta),
    .s2_left_pos_o    (s2_lpos),
    .s2_right_pos_o   (s2_rpos),
    .rd_en_o          (rd_en),
    .rd_slot_o        (rd_slot)
  );

  dqps_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s2_ctrl_i        (s2_ctrl),
    .s2_fire_i        (s2_fire),
    .s2_slot_i        (s2_slot),
    .s2_left_delta_i  (s2_ldelta),
    .s2_right_delta_i (s2_rdelta),
    .rd_en_i          (rd_en),
    .rd_slot_i        (rd_slot),
    .left_speed_o     (left_speed),
    .right_speed_o    (right_speed)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_data_q <= {right_speed, left_speed, s2_rpos, s2_lpos};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // input is held off only when both stages are full and the output stalls
  `DQPS_ASSERT(a_ready_when_room, (!s2_ctrl.valid || !out_valid_q) |-> s_axis_tready_o)

endmodule

[rtl/dqps_decode.sv]
// ---------------------------------------------------------------------------
// dqps_decode
// Pin decode, position counters and tick bookkeeping; feeds the ring stage
// ---------------------------------------------------------------------------
module dqps_decode #(
  parameter int unsigned WINDOW_DEPTH = 32,
  localparam int unsigned SlotW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_fire_i,
  input  logic [dqps_pkg::ModeW-1:0]  mode_i,
  input  logic [3:0]                  pins_i,   // left_a, left_b, right_a, right_b
  input  logic                        s2_fire_i,
  output dqps_pkg::stage_ctrl_t       s2_ctrl_o,
  output logic [SlotW-1:0]            s2_slot_o,
  output logic [dqps_pkg::CountW-1:0] s2_left_delta_o,
  output logic [dqps_pkg::CountW-1:0] s2_right_delta_o,
  output logic [dqps_pkg::CountW-1:0] s2_left_pos_o,
  output logic [dqps_pkg::CountW-1:0] s2_right_pos_o,
  output logic                        rd_en_o,
  output logic [SlotW-1:0]            rd_slot_o
);

  localparam int unsigned CW = dqps_pkg::CountW;

  logic [CW-1:0]    left_cnt_q, left_cnt_d, right_cnt_q, right_cnt_d;
  logic [CW-1:0]    left_at_q, left_at_d, right_at_q, right_at_d;
  logic [3:0]       prev_q, prev_d;
  logic [SlotW-1:0] slot_q, slot_d, slot_next;
  logic [1:0]       step_l, step_r;
  logic [CW-1:0]    left_next, right_next, left_delta, right_delta;
  logic             is_tick, is_clear;

  dqps_pkg::stage_ctrl_t s2_ctrl_q;
  logic [SlotW-1:0]      s2_slot_q;
  logic [CW-1:0]         s2_ldelta_q, s2_rdelta_q, s2_lpos_q, s2_rpos_q;

  // decode of the sampled pins
  always_comb begin
    is_clear    = (mode_i == dqps_pkg::MODE_CLEAR);
    is_tick     = (mode_i == dqps_pkg::MODE_TICK);
    step_l      = dqps_pkg::quad_step(prev_q[0], prev_q[1], pins_i[0], pins_i[1]);
    step_r      = dqps_pkg::quad_step(prev_q[2], prev_q[3], pins_i[2], pins_i[3]);
    left_next   = left_cnt_q + {{(CW-2){step_l[1]}}, step_l};
    right_next  = right_cnt_q + {{(CW-2){step_r[1]}}, step_r};
    left_delta  = left_next - left_at_q;
    right_delta = right_next - right_at_q;
    slot_next   = (slot_q == SlotW'(WINDOW_DEPTH - 1)) ? '0 : SlotW'(slot_q + 1'b1);
  end

  // next state of the scalar counters
  always_comb begin
    left_cnt_d  = left_cnt_q;
    right_cnt_d = right_cnt_q;
    left_at_d   = left_at_q;
    right_at_d  = right_at_q;
    prev_d      = prev_q;
    slot_d      = slot_q;
    if (in_fire_i) begin
      if (is_clear) begin
        left_cnt_d  = '0;
        right_cnt_d = '0;
        left_at_d   = '0;
        right_at_d  = '0;
        slot_d      = '0;
      end else begin
        left_cnt_d  = left_next;
        right_cnt_d = right_next;
        prev_d      = pins_i;
        if (is_tick) begin
          left_at_d  = left_next;
          right_at_d = right_next;
          slot_d     = slot_next;
        end
      end
    end
  end

  // scalar state, pins idle high after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cnt_q  <= '0;
      right_cnt_q <= '0;
      left_at_q   <= '0;
      right_at_q  <= '0;
      prev_q      <= 4'hF;
      slot_q      <= '0;
    end else begin
      left_cnt_q  <= left_cnt_d;
      right_cnt_q <= right_cnt_d;
      left_at_q   <= left_at_d;
      right_at_q  <= right_at_d;
      prev_q      <= prev_d;
      slot_q      <= slot_d;
    end
  end

  // second stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctrl_q <= '0;
    end else if (in_fire_i) begin
      s2_ctrl_q.valid <= 1'b1;
      s2_ctrl_q.tick  <= is_tick;
      s2_ctrl_q.clear <= is_clear;
    end else if (s2_fire_i) begin
      s2_ctrl_q.valid <= 1'b0;
    end
  end

  // second stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s2_slot_q   <= slot_q;
      s2_ldelta_q <= left_delta;
      s2_rdelta_q <= right_delta;
      s2_lpos_q   <= is_clear ? '0 : left_next;
      s2_rpos_q   <= is_clear ? '0 : right_next;
    end
  end

  assign s2_ctrl_o        = s2_ctrl_q;
  assign s2_slot_o        = s2_slot_q;
  assign s2_left_delta_o  = s2_ldelta_q;
  assign s2_right_delta_o = s2_rdelta_q;
  assign s2_left_pos_o    = s2_lpos_q;
  assign s2_right_pos_o   = s2_rpos_q;
  assign rd_en_o          = in_fire_i && is_tick;
  assign rd_slot_o        = slot_q;

endmodule

[rtl/dqps_window.sv]
// ---------------------------------------------------------------------------
// dqps_window
// Delta ring memory with per-entry valid flags and the running window sums
// ---------------------------------------------------------------------------
`include "dual_quadrature_position_speed_unit_defines.svh"

module dqps_window #(
  parameter int unsigned WINDOW_DEPTH = 32,
  localparam int unsigned SlotW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dqps_pkg::stage_ctrl_t       s2_ctrl_i,
  input  logic                        s2_fire_i,
  input  logic [SlotW-1:0]            s2_slot_i,
  input  logic [dqps_pkg::CountW-1:0] s2_left_delta_i,
  input  logic [dqps_pkg::CountW-1:0] s2_right_delta_i,
  input  logic                        rd_en_i,
  input  logic [SlotW-1:0]            rd_slot_i,
  output logic [dqps_pkg::CountW-1:0] left_speed_o,
  output logic [dqps_pkg::CountW-1:0] right_speed_o
);

  localparam int unsigned CW = dqps_pkg::CountW;

  // left delta in the low half, right delta in the high half
  logic [2*CW-1:0]         ring_mem [WINDOW_DEPTH];
  logic [2*CW-1:0]         rd_data_q;
  logic                    rd_valid_q;
  logic [WINDOW_DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]           left_sum_q, left_sum_d, right_sum_q, right_sum_d;
  logic [CW-1:0]           left_old, right_old, left_new, right_new;
  logic                    wr_en, clr_en;

  assign wr_en  = s2_fire_i && s2_ctrl_i.tick;
  assign clr_en = s2_fire_i && s2_ctrl_i.clear;

  // ring memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= ring_mem[rd_slot_i];
    end
    if (wr_en) begin
      ring_mem[s2_slot_i] <= {s2_right_delta_i, s2_left_delta_i};
    end
  end

  // valid flag read alongside the data, a clear leaving stage two wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_valid_q <= valid_q[rd_slot_i] && !clr_en;
    end
  end

  // entries never written since the last clear read as zero
  always_comb begin
    left_old  = rd_valid_q ? rd_data_q[CW-1:0]    : '0;
    right_old = rd_valid_q ? rd_data_q[2*CW-1:CW] : '0;
    left_new  = left_sum_q - left_old + s2_left_delta_i;
    right_new = right_sum_q - right_old + s2_right_delta_i;
  end

  // window sums and valid flags
  always_comb begin
    valid_d     = valid_q;
    left_sum_d  = left_sum_q;
    right_sum_d = right_sum_q;
    if (clr_en) begin
      valid_d     = '0;
      left_sum_d  = '0;
      right_sum_d = '0;
    end else if (wr_en) begin
      valid_d[s2_slot_i] = 1'b1;
      left_sum_d         = left_new;
      right_sum_d        = right_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      left_sum_q  <= '0;
      right_sum_q <= '0;
    end else begin
      valid_q     <= valid_d;
      left_sum_q  <= left_sum_d;
      right_sum_q <= right_sum_d;
    end
  end

  // speed as seen after the item in stage two
  always_comb begin
    left_speed_o  = left_sum_q;
    right_speed_o = right_sum_q;
    if (s2_ctrl_i.clear) begin
      left_speed_o  = '0;
      right_speed_o = '0;
    end else if (s2_ctrl_i.tick) begin
      left_speed_o  = left_new;
      right_speed_o = right_new;
    end
  end

  // a clear empties the whole ring and both sums
  `DQPS_ASSERT(a_clear_empties, clr_en |=> (valid_q == '0) && (left_sum_q == '0) && (right_sum_q == '0))
  // a tick leaves its slot marked as written
  `DQPS_ASSERT(a_tick_marks_slot, wr_en |=> valid_q[$past(s2_slot_i)])
  // stage two never carries a tick and a clear together
  `DQPS_ASSERT_NEVER(a_tick_and_clear, s2_ctrl_i.valid && s2_ctrl_i.tick && s2_ctrl_i.clear)

endmodule

[dv/dqps_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dqps_checker
// Watches the sample and result streams of the dual quadrature unit, keeps
// its own copy of the position, ring and sum state, and compares every
// result transfer field by field with the oldest predicted report
// ---------------------------------------------------------------------------
module dqps_checker #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [7:0]   s_tdata_i,   // mode[1:0], left_a, left_b, right_a, right_b, zeros
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [127:0] m_tdata_i,   // left_position, right_position, left_speed, right_speed
  output int           fail_count_o,
  output int           pending_o
);

  localparam int unsigned CountW = dqps_pkg::CountW;
  localparam int unsigned ModeW  = dqps_pkg::ModeW;

  // one predicted result transfer
  typedef struct packed {
    logic signed [CountW-1:0] left_pos;
    logic signed [CountW-1:0] right_pos;
    logic signed [CountW-1:0] left_speed;
    logic signed [CountW-1:0] right_speed;
  } wheel_report_t;

  // predicted encoder state
  logic [CountW-1:0] left_pos;
  logic [CountW-1:0] right_pos;
  logic [CountW-1:0] left_mark;
  logic [CountW-1:0] right_mark;
  logic [CountW-1:0] left_sum;
  logic [CountW-1:0] right_sum;
  logic [CountW-1:0] left_deltas [WINDOW_DEPTH];
  logic [CountW-1:0] right_deltas [WINDOW_DEPTH];
  logic [3:0]        pins_seen;    // left_a, left_b, right_a, right_b from bit 0
  int unsigned       slot;

  wheel_report_t report_q [$];

  // signed x4 increment of one encoder, wrapping in 32 bits
  function automatic logic [CountW-1:0] pin_increment(input logic old_a, input logic old_b,
                                                      input logic a, input logic b);
    logic [CountW-1:0] inc;
    inc = '0;
    if (old_a != a) begin
      inc = inc + ((a == b) ? 32'd1 : 32'hFFFF_FFFF);
    end
    if (old_b != b) begin
      inc = inc + ((a == b) ? 32'hFFFF_FFFF : 32'd1);
    end
    return inc;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string field, input logic [CountW-1:0] got,
                             input logic [CountW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", field,
                                $signed(got), $signed(want)));
    end
  endtask

  // zero counts, marks, rings, sums and slot; pin history is left alone
  task automatic clear_counts();
    left_pos   = '0;
    right_pos  = '0;
    left_mark  = '0;
    right_mark = '0;
    left_sum   = '0;
    right_sum  = '0;
    slot       = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      left_deltas[i]  = '0;
      right_deltas[i] = '0;
    end
  endtask

  // apply one accepted sample and queue the report it produces
  task automatic track_sample(input logic [7:0] sample);
    logic [ModeW-1:0]  mode;
    logic [3:0]        pins;
    logic [CountW-1:0] left_delta;
    logic [CountW-1:0] right_delta;
    mode = sample[ModeW-1:0];
    pins = sample[5:2];
    if (mode == dqps_pkg::MODE_CLEAR) begin
      clear_counts();
    end else begin
      left_pos  = left_pos + pin_increment(pins_seen[0], pins_seen[1], pins[0], pins[1]);
      right_pos = right_pos + pin_increment(pins_seen[2], pins_seen[3], pins[2], pins[3]);
      pins_seen = pins;
      if (mode == dqps_pkg::MODE_TICK) begin
        left_delta         = left_pos - left_mark;
        right_delta        = right_pos - right_mark;
        left_sum           = left_sum - left_deltas[slot] + left_delta;
        right_sum          = right_sum - right_deltas[slot] + right_delta;
        left_deltas[slot]  = left_delta;
        right_deltas[slot] = right_delta;
        left_mark          = left_pos;
        right_mark         = right_pos;
        slot               = (slot + 1 == WINDOW_DEPTH) ? 0 : slot + 1;
      end
    end
    report_q.push_back('{left_pos, right_pos, left_sum, right_sum});
  endtask

  // sample on every edge, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin : watch
    wheel_report_t want;
    if (!rst_ni) begin
      clear_counts();
      pins_seen = '1;
      report_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        track_sample(s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (report_q.size() == 0) begin
          report_mismatch("result transfer with no sample outstanding");
        end else begin
          want = report_q.pop_front();
          check_field("left_position", m_tdata_i[31:0], want.left_pos);
          check_field("right_position", m_tdata_i[63:32], want.right_pos);
          check_field("left_speed", m_tdata_i[95:64], want.left_speed);
          check_field("right_speed", m_tdata_i[127:96], want.right_speed);
        end
      end
      pending_o <= report_q.size();
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dual quadrature position and speed unit:
// directed pin walks, ticks and clears, then random encoder walks under
// several sender and receiver idling mixes, with a long output hold-off
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned     WINDOW_DEPTH = 32;
  localparam int              CLK_PERIOD   = 20;
  localparam int              LONG_HOLD    = 300;
  localparam longint          TIMEOUT_NS   = 64'd4_000_000;
  // the spare mode code, which must act as a plain sample
  localparam logic [dqps_pkg::ModeW-1:0] MODE_UNUSED = 2'd3;

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i  = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;

  int fail_total;
  int pending_results;

  // idling controls and long hold-off request
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // pin levels last sent, {b, a} per encoder
  logic [1:0] left_pins  = 2'b11;
  logic [1:0] right_pins = 2'b11;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  dual_quadrature_position_speed_unit #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  dqps_checker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_i  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tvalid_i  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_i   (m_axis_tdata_o),
    .fail_count_o(fail_total),
    .pending_o   (pending_results)
  );

  // receiver: random stalls, or a long hold-off counted down here
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one quarter step of the gray sequence, forward or backward
  function automatic logic [1:0] rotate(input logic [1:0] pins, input bit fwd);
    logic [1:0] next;
    next = pins;
    if ((pins[0] == pins[1]) == fwd) begin
      next[0] = ~pins[0];
    end else begin
      next[1] = ~pins[1];
    end
    return next;
  endfunction

  // mostly clean steps, some simultaneous flips of both pins, some holds
  function automatic logic [1:0] wander(input logic [1:0] pins);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) begin
      return rotate(pins, 1'b1);
    end else if (r < 70) begin
      return rotate(pins, 1'b0);
    end else if (r < 76) begin
      return ~pins;
    end
    return pins;
  endfunction

  // offer one sample and wait for its transfer
  task automatic send_pins(input logic [dqps_pkg::ModeW-1:0] mode, input logic [1:0] lp,
                           input logic [1:0] rp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, rp, lp, mode};
    do @(posedge clk_i); while (!s_axis_tready_o);
    // a clear ignores the pins, so the encoders stay where they were
    if (mode != dqps_pkg::MODE_CLEAR) begin
      left_pins  = lp;
      right_pins = rp;
    end
  endtask

  task automatic random_item();
    int unsigned r;
    logic [dqps_pkg::ModeW-1:0] mode;
    r = $urandom_range(99);
    if (r < 3) begin
      mode = dqps_pkg::MODE_CLEAR;
    end else if (r < 8) begin
      mode = MODE_UNUSED;
    end else if (r < 28) begin
      mode = dqps_pkg::MODE_TICK;
    end else begin
      mode = dqps_pkg::MODE_SAMPLE;
    end
    if (mode == dqps_pkg::MODE_CLEAR) begin
      send_pins(mode, 2'($urandom_range(3)), 2'($urandom_range(3)));
    end else begin
      send_pins(mode, wander(left_pins), wander(right_pins));
    end
  endtask

  // stop offering until every result has been taken
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic run_phase(input int items, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) random_item();
    drain();
  endtask

  // run time limit
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle levels, full turns both ways, cancelling flips, ticks and clears
    send_pins(dqps_pkg::MODE_SAMPLE, 2'b11, 2'b11);
    repeat (4) send_pins(dqps_pkg::MODE_SAMPLE, rotate(left_pins, 1'b1), right_pins);
    send_pins(dqps_pkg::MODE_TICK, left_pins, right_pins);
    repeat (5) send_pins(dqps_pkg::MODE_SAMPLE, left_pins, rotate(right_pins, 1'b0));
    send_pins(dqps_pkg::MODE_TICK, left_pins, right_pins);
    send_pins(dqps_pkg::MODE_SAMPLE, ~left_pins, ~right_pins);
    send_pins(MODE_UNUSED, rotate(left_pins, 1'b0), rotate(right_pins, 1'b1));
    send_pins(dqps_pkg::MODE_TICK, rotate(left_pins, 1'b0), right_pins);
    send_pins(dqps_pkg::MODE_CLEAR, ~left_pins, ~right_pins);
    send_pins(dqps_pkg::MODE_TICK, left_pins, right_pins);
    send_pins(dqps_pkg::MODE_SAMPLE, rotate(left_pins, 1'b1), rotate(right_pins, 1'b1));
    send_pins(dqps_pkg::MODE_TICK, rotate(left_pins, 1'b1), rotate(right_pins, 1'b0));
    send_pins(dqps_pkg::MODE_CLEAR, left_pins, right_pins);
    send_pins(dqps_pkg::MODE_CLEAR, ~left_pins, right_pins);
    drain();

    // random walks under each idling mix
    run_phase(130, 0, 0);
    run_phase(130, 65, 0);
    run_phase(130, 0, 65);
    run_phase(130, 24, 24);

    // long output hold-off while samples keep coming, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    repeat (24) random_item();
    drain();

    repeat (8) @(posedge clk_i);
    if (fail_total == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
